>>> src/gpioevt_pkg.sv
// Shared types, register map and constants of the GPIO register block.
package gpioevt_pkg;

  localparam int unsigned PinCountDefault = 54;
  localparam int unsigned MaxPins         = 64;
  localparam int unsigned PinOutWidth     = 54;
  localparam int unsigned PinsPerWord     = 10;
  localparam int unsigned FselWords       = 6;
  localparam int unsigned SdPinFirst      = 48;
  localparam int unsigned SdPinLast       = 53;

  localparam logic [2:0] FselInput  = 3'd0;
  localparam logic [2:0] FselOutput = 3'd1;
  localparam logic [2:0] FselAlt0   = 3'd4;

  localparam logic [11:0] AddrFsel0  = 12'h000;
  localparam logic [11:0] AddrFsel1  = 12'h004;
  localparam logic [11:0] AddrFsel2  = 12'h008;
  localparam logic [11:0] AddrFsel3  = 12'h00C;
  localparam logic [11:0] AddrFsel4  = 12'h010;
  localparam logic [11:0] AddrFsel5  = 12'h014;
  localparam logic [11:0] AddrSet0   = 12'h01C;
  localparam logic [11:0] AddrSet1   = 12'h020;
  localparam logic [11:0] AddrClr0   = 12'h028;
  localparam logic [11:0] AddrClr1   = 12'h02C;
  localparam logic [11:0] AddrLev0   = 12'h034;
  localparam logic [11:0] AddrLev1   = 12'h038;
  localparam logic [11:0] AddrEds0   = 12'h040;
  localparam logic [11:0] AddrEds1   = 12'h044;
  localparam logic [11:0] AddrRen0   = 12'h04C;
  localparam logic [11:0] AddrRen1   = 12'h050;
  localparam logic [11:0] AddrFen0   = 12'h058;
  localparam logic [11:0] AddrFen1   = 12'h05C;
  localparam logic [11:0] AddrHen0   = 12'h064;
  localparam logic [11:0] AddrHen1   = 12'h068;
  localparam logic [11:0] AddrLen0   = 12'h070;
  localparam logic [11:0] AddrLen1   = 12'h074;
  localparam logic [11:0] AddrAren0  = 12'h07C;
  localparam logic [11:0] AddrAren1  = 12'h080;
  localparam logic [11:0] AddrAfen0  = 12'h088;
  localparam logic [11:0] AddrAfen1  = 12'h08C;
  localparam logic [11:0] AddrPud    = 12'h094;
  localparam logic [11:0] AddrPudClk0 = 12'h098;
  localparam logic [11:0] AddrPudClk1 = 12'h09C;

  localparam logic [31:0] Irq0Mask0 = 32'h0fffffff;
  localparam logic [31:0] Irq1Mask0 = 32'hf0000000;
  localparam logic [31:0] Irq1Mask1 = 32'h00003fff;
  localparam logic [31:0] Irq2Mask1 = 32'h003fc000;

  typedef enum logic [3:0] {
    OpFsel   = 4'd0,
    OpSet    = 4'd1,
    OpClr    = 4'd2,
    OpLevel  = 4'd3,
    OpStatus = 4'd4,
    OpRise   = 4'd5,
    OpFall   = 4'd6,
    OpHigh   = 4'd7,
    OpLow    = 4'd8,
    OpARise  = 4'd9,
    OpAFall  = 4'd10,
    OpPull   = 4'd11,
    OpBad    = 4'd12
  } gpio_op_e;

  typedef struct packed {
    logic        mode;
    logic [11:0] address;
    logic [31:0] write_data;
  } gpio_in_t;

  typedef struct packed {
    logic [31:0]            read_data;
    logic [2:0]             irq_lines;
    logic [PinOutWidth-1:0] pin_outputs;
    logic                   sd_route;
    logic                   bad_offset;
  } gpio_out_t;

endpackage

>>> src/gpio_register_block_with_event_detect_core.sv
// GPIO controller register block with edge and level event detection.
//
// One bus transaction per cycle: a read or write is accepted whenever the
// result register is free or being drained, and its result (read data, interrupt
// lines, driven pin levels, SD route, bad-offset flag) appears in the result
// register in the next cycle, reflecting the state after the access. All decode,
// set/clear, event latching and select packing is a single pass of bitwise
// logic from the state registers and the incoming transaction into the state
// and result registers, so the sustained rate is one transaction per cycle and
// only back-pressure on the result side slows it. PIN_COUNT (33 to 64) sets how
// many function selects and output levels are stored.
module gpio_register_block_with_event_detect_core
  import gpioevt_pkg::*;
#(
  parameter int unsigned PIN_COUNT = PinCountDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  gpio_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output gpio_out_t out_data_o
);

  // state
  logic [2:0]           fsel_q [PIN_COUNT];
  logic [PIN_COUNT-1:0] out_lvl_q, out_lvl_d;
  logic [31:0]          lvl_q [2], lvl_d [2];
  logic [31:0]          eds_q [2], eds_d [2];
  logic [31:0]          ren_q [2], ren_d [2];
  logic [31:0]          fen_q [2], fen_d [2];
  logic [31:0]          hen_q [2], hen_d [2];
  logic [31:0]          len_q [2], len_d [2];
  logic [31:0]          aren_q [2], aren_d [2];
  logic [31:0]          afen_q [2], afen_d [2];
  logic                 sd_q, sd_d;

  logic      out_valid_q;
  gpio_out_t out_q, out_d;

  logic       accept, wr, fsel_wr, is_mask;
  gpio_op_e   op;
  logic       bank;
  logic [2:0] word;
  logic [31:0] wdata;
  logic [31:0] rd;
  logic [31:0] ch [2];
  logic [2:0]  sel_cur [MaxPins];
  logic [2:0]  sel_new [MaxPins];
  logic [31:0] packed_w [8];
  logic [MaxPins-1:0] out_lvl_wide;
  logic        all0, all4;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign wr         = accept && in_data_i.mode;
  assign wdata      = in_data_i.write_data;
  assign word       = in_data_i.address[4:2];
  assign fsel_wr    = wr && (op == OpFsel);
  assign is_mask    = (op == OpRise) || (op == OpFall) || (op == OpHigh) ||
                      (op == OpLow) || (op == OpARise) || (op == OpAFall);

  // address decode
  always_comb begin
    op   = OpBad;
    bank = 1'b0;
    case (in_data_i.address)
      AddrFsel0, AddrFsel1, AddrFsel2,
      AddrFsel3, AddrFsel4, AddrFsel5: op = OpFsel;
      AddrSet0:  op = OpSet;
      AddrSet1:  begin op = OpSet;    bank = 1'b1; end
      AddrClr0:  op = OpClr;
      AddrClr1:  begin op = OpClr;    bank = 1'b1; end
      AddrLev0:  op = OpLevel;
      AddrLev1:  begin op = OpLevel;  bank = 1'b1; end
      AddrEds0:  op = OpStatus;
      AddrEds1:  begin op = OpStatus; bank = 1'b1; end
      AddrRen0:  op = OpRise;
      AddrRen1:  begin op = OpRise;   bank = 1'b1; end
      AddrFen0:  op = OpFall;
      AddrFen1:  begin op = OpFall;   bank = 1'b1; end
      AddrHen0:  op = OpHigh;
      AddrHen1:  begin op = OpHigh;   bank = 1'b1; end
      AddrLen0:  op = OpLow;
      AddrLen1:  begin op = OpLow;    bank = 1'b1; end
      AddrAren0: op = OpARise;
      AddrAren1: begin op = OpARise;  bank = 1'b1; end
      AddrAfen0: op = OpAFall;
      AddrAfen1: begin op = OpAFall;  bank = 1'b1; end
      AddrPud, AddrPudClk0, AddrPudClk1: op = OpPull;
      default:   op = OpBad;
    endcase
  end

  // per-pin select view; absent pins read as input select
  for (genvar p = 0; p < MaxPins; p++) begin : g_pin
    if (p < PIN_COUNT) begin : g_has
      assign sel_cur[p] = fsel_q[p];
      assign sel_new[p] = (fsel_wr && (word == 3'(p / PinsPerWord))) ?
                          wdata[3*(p % PinsPerWord) +: 3] : fsel_q[p];
      assign out_lvl_d[p] = (ch[p / 32][p % 32] && (sel_cur[p] == FselOutput)) ?
                            (op == OpSet) : out_lvl_q[p];
    end else begin : g_none
      assign sel_cur[p] = FselInput;
      assign sel_new[p] = FselInput;
    end
  end

  // packed select words for reads; words past the map read zero
  for (genvar w = 0; w < 8; w++) begin : g_word
    if (w < FselWords) begin : g_used
      for (genvar i = 0; i < PinsPerWord; i++) begin : g_slot
        assign packed_w[w][3*i +: 3] = sel_cur[PinsPerWord*w + i];
      end
      assign packed_w[w][31:3*PinsPerWord] = '0;
    end else begin : g_unused
      assign packed_w[w] = '0;
    end
  end

  // level, event and mask update per bank
  always_comb begin
    logic det;
    for (int b = 0; b < 2; b++) begin
      det       = 1'b0;
      ch[b]     = '0;
      lvl_d[b]  = lvl_q[b];
      eds_d[b]  = eds_q[b];
      ren_d[b]  = ren_q[b];
      fen_d[b]  = fen_q[b];
      hen_d[b]  = hen_q[b];
      len_d[b]  = len_q[b];
      aren_d[b] = aren_q[b];
      afen_d[b] = afen_q[b];
      if (wr && (bank == 1'(b))) begin
        case (op)
          OpSet: begin
            ch[b]    = wdata & ~lvl_q[b];
            lvl_d[b] = lvl_q[b] | wdata;
            eds_d[b] = eds_q[b] | ((ren_q[b] | aren_q[b]) & ch[b]);
            det      = 1'b1;
          end
          OpClr: begin
            ch[b]    = wdata & lvl_q[b];
            lvl_d[b] = lvl_q[b] & ~wdata;
            eds_d[b] = eds_q[b] | ((fen_q[b] | afen_q[b]) & ch[b]);
            det      = 1'b1;
          end
          OpStatus: eds_d[b]  = eds_q[b] & ~wdata;
          OpRise:   ren_d[b]  = wdata;
          OpFall:   fen_d[b]  = wdata;
          OpHigh:   hen_d[b]  = wdata;
          OpLow:    len_d[b]  = wdata;
          OpARise:  aren_d[b] = wdata;
          OpAFall:  afen_d[b] = wdata;
          default:  ;
        endcase
      end
      // a mask write rescans levels on both banks
      if (wr && is_mask) det = 1'b1;
      if (det) begin
        eds_d[b] = eds_d[b] | (hen_d[b] & lvl_d[b]) | (len_d[b] & ~lvl_d[b]);
      end
    end
  end

  // SD route from the selects of pins 48 to 53
  always_comb begin
    all0 = 1'b1;
    all4 = 1'b1;
    for (int p = SdPinFirst; p <= SdPinLast; p++) begin
      if (sel_new[p] != FselInput) all0 = 1'b0;
      if (sel_new[p] != FselAlt0)  all4 = 1'b0;
    end
    sd_d = sd_q;
    if (fsel_wr) begin
      if (all0)      sd_d = 1'b0;
      else if (all4) sd_d = 1'b1;
    end
  end

  // read mux
  always_comb begin
    rd = '0;
    if (!in_data_i.mode) begin
      case (op)
        OpFsel:   rd = packed_w[word];
        OpLevel:  rd = lvl_q[bank];
        OpStatus: rd = eds_q[bank];
        OpRise:   rd = ren_q[bank];
        OpFall:   rd = fen_q[bank];
        OpHigh:   rd = hen_q[bank];
        OpLow:    rd = len_q[bank];
        OpARise:  rd = aren_q[bank];
        OpAFall:  rd = afen_q[bank];
        default:  rd = '0;
      endcase
    end
  end

  assign out_lvl_wide = MaxPins'(out_lvl_d);

  always_comb begin
    out_d.read_data   = rd;
    out_d.irq_lines[0] = |(eds_d[0] & Irq0Mask0);
    out_d.irq_lines[1] = |(eds_d[0] & Irq1Mask0) || |(eds_d[1] & Irq1Mask1);
    out_d.irq_lines[2] = |(eds_d[1] & Irq2Mask1);
    out_d.pin_outputs = out_lvl_wide[PinOutWidth-1:0];
    out_d.sd_route    = sd_d;
    out_d.bad_offset  = (op == OpBad);
  end

  // state registers; next values equal current ones unless a write is accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PIN_COUNT; p++) fsel_q[p] <= FselInput;
      for (int b = 0; b < 2; b++) begin
        lvl_q[b]  <= '0;
        eds_q[b]  <= '0;
        ren_q[b]  <= '0;
        fen_q[b]  <= '0;
        hen_q[b]  <= '0;
        len_q[b]  <= '0;
        aren_q[b] <= '0;
        afen_q[b] <= '0;
      end
      out_lvl_q <= '0;
      sd_q      <= 1'b0;
    end else begin
      for (int p = 0; p < PIN_COUNT; p++) fsel_q[p] <= sel_new[p];
      for (int b = 0; b < 2; b++) begin
        lvl_q[b]  <= lvl_d[b];
        eds_q[b]  <= eds_d[b];
        ren_q[b]  <= ren_d[b];
        fen_q[b]  <= fen_d[b];
        hen_q[b]  <= hen_d[b];
        len_q[b]  <= len_d[b];
        aren_q[b] <= aren_d[b];
        afen_q[b] <= afen_d[b];
      end
      out_lvl_q <= out_lvl_d;
      sd_q      <= sd_d;
    end
  end

  // result register: load on accept, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> tb/sv/tb_gpio_register_block_with_event_detect_core.sv
// Self-checking testbench for the GPIO register block with event detection.
module tb_gpio_register_block_with_event_detect_core;
  import gpioevt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic        ModeRd      = 1'b0;
  localparam logic        ModeWr      = 1'b1;
  localparam logic [31:0] FselAllOut  = 32'h0924_9249;
  localparam logic [31:0] FselAllAlt0 = 32'h2492_4924;
  localparam int unsigned EnStride    = 12;
  localparam int unsigned PhaseItems  = 550;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;

  // enable mask slots, in the order of the enable operations
  localparam int SlotRise  = 0;
  localparam int SlotFall  = 1;
  localparam int SlotHigh  = 2;
  localparam int SlotLow   = 3;
  localparam int SlotARise = 4;
  localparam int SlotAFall = 5;

  typedef struct packed {
    gpio_in_t    acc;
    logic        known;
    logic [31:0] rd;
    logic        bad;
  } access_row_t;

  localparam access_row_t DirTable [26] = '{
    '{'{ModeRd, AddrFsel0,   32'h0000_0000}, 1'b1, 32'h0000_0000, 1'b0},
    '{'{ModeRd, AddrLev1,    32'h0000_0000}, 1'b1, 32'h0000_0000, 1'b0},
    '{'{ModeRd, 12'hFFF,     32'hFFFF_FFFF}, 1'b1, 32'h0000_0000, 1'b1},
    '{'{ModeWr, 12'h018,     32'hFFFF_FFFF}, 1'b1, 32'h0000_0000, 1'b1},
    '{'{ModeWr, AddrFsel0,   32'hFFFF_FFFF}, 1'b1, 32'h0000_0000, 1'b0},
    '{'{ModeRd, AddrFsel0,   32'h0000_0000}, 1'b1, 32'h3FFF_FFFF, 1'b0},
    '{'{ModeWr, AddrFsel0,   FselAllOut   }, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrRen0,    32'hFFFF_FFFF}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrFen0,    32'hFFFF_FFFF}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrSet0,    32'hFFFF_FFFF}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeRd, AddrEds0,    32'h0000_0000}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrEds0,    32'hFFFF_FFFF}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrClr0,    32'h0000_FFFF}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrSet1,    32'hFFFF_FFFF}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeRd, AddrLev1,    32'h0000_0000}, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{'{ModeWr, AddrAren1,   32'h8000_0001}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrAfen1,   32'hFFFF_FFFF}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrClr1,    32'h00C0_0003}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrHen1,    32'hFFFF_FFFF}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrLen0,    32'hFFFF_FFFF}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrFsel4,   32'h2400_0000}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrFsel5,   32'hFFFF_F924}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeRd, AddrFsel5,   32'h0000_0000}, 1'b1, 32'h0000_0924, 1'b0},
    '{'{ModeWr, AddrFsel5,   32'h0000_0000}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeWr, AddrFsel4,   32'h0000_0000}, 1'b0, 32'h0000_0000, 1'b0},
    '{'{ModeRd, AddrPud,     32'hFFFF_FFFF}, 1'b1, 32'h0000_0000, 1'b0}
  };

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_stall;
  gpio_in_t  in_data    = '0;
  logic      out_valid;
  logic      out_stall  = 1'b0;
  gpio_out_t out_data;
  logic      rx_hold    = 1'b0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned err_cnt     = 0;
  int unsigned n_checked   = 0;
  int unsigned n_rd        = 0;
  int unsigned n_wr        = 0;
  int unsigned n_irq       = 0;
  int unsigned n_sd2       = 0;
  bit          kind_seen [gpio_op_e];
  event        hold_ev;

  // expected results of accepted transactions, oldest first
  gpio_out_t pending_results [$];

  // predicted register state
  logic [2:0]  fsel_q [MaxPins] = '{default: FselInput};
  logic [31:0] lev_q  [2]       = '{default: '0};
  logic [31:0] eds_q  [2]       = '{default: '0};
  logic [31:0] en_q   [6][2]    = '{default: '{default: '0}};
  logic [63:0] drv_q            = '0;
  logic        sd_q             = 1'b0;

  gpio_register_block_with_event_detect_core #(
    .PIN_COUNT(PinCountDefault)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic gpio_op_e decode_addr(input logic [11:0] a, output int unsigned idx);
    idx = 0;
    if (a <= AddrFsel5 && a[1:0] == 2'b00) begin
      idx = 32'(a[11:2]);
      return OpFsel;
    end
    case (a)
      AddrSet0, AddrSet1: begin
        idx = 32'(a == AddrSet1);
        return OpSet;
      end
      AddrClr0, AddrClr1: begin
        idx = 32'(a == AddrClr1);
        return OpClr;
      end
      AddrLev0, AddrLev1: begin
        idx = 32'(a == AddrLev1);
        return OpLevel;
      end
      AddrEds0, AddrEds1: begin
        idx = 32'(a == AddrEds1);
        return OpStatus;
      end
      AddrRen0, AddrRen1: begin
        idx = 32'(a == AddrRen1);
        return OpRise;
      end
      AddrFen0, AddrFen1: begin
        idx = 32'(a == AddrFen1);
        return OpFall;
      end
      AddrHen0, AddrHen1: begin
        idx = 32'(a == AddrHen1);
        return OpHigh;
      end
      AddrLen0, AddrLen1: begin
        idx = 32'(a == AddrLen1);
        return OpLow;
      end
      AddrAren0, AddrAren1: begin
        idx = 32'(a == AddrAren1);
        return OpARise;
      end
      AddrAfen0, AddrAfen1: begin
        idx = 32'(a == AddrAfen1);
        return OpAFall;
      end
      AddrPud, AddrPudClk0, AddrPudClk1: return OpPull;
      default: return OpBad;
    endcase
  endfunction

  function automatic void latch_levels(input int unsigned b);
    eds_q[b] |= (en_q[SlotHigh][b] & lev_q[b]) | (en_q[SlotLow][b] & ~lev_q[b]);
  endfunction

  // Apply one bus transaction to the predicted state and return its result.
  function automatic gpio_out_t predict_access(input gpio_in_t acc);
    gpio_out_t   res;
    gpio_op_e    op;
    int unsigned idx;
    int unsigned p;
    int          slot;
    logic [31:0] rd;
    logic [31:0] v;
    logic [31:0] chg;
    logic        all0;
    logic        all4;
    rd = '0;
    v  = acc.write_data;
    op = decode_addr(acc.address, idx);
    slot = int'(op) - int'(OpRise);
    case (op)
      OpFsel: begin
        for (int i = 0; i < PinsPerWord; i++) begin
          p = PinsPerWord * idx + i;
          if (p < PinCountDefault) begin
            if (acc.mode == ModeWr) fsel_q[p] = v[3*i +: 3];
            else rd[3*i +: 3] = fsel_q[p];
          end
        end
        if (acc.mode == ModeWr) begin
          all0 = 1'b1;
          all4 = 1'b1;
          for (int q = SdPinFirst; q <= SdPinLast; q++) begin
            if (fsel_q[q] != FselInput) all0 = 1'b0;
            if (fsel_q[q] != FselAlt0) all4 = 1'b0;
          end
          // mixed selects leave the route where it was
          if (all0) sd_q = 1'b0;
          else if (all4) sd_q = 1'b1;
        end
      end
      OpSet, OpClr: begin
        if (acc.mode == ModeWr) begin
          chg = (op == OpSet) ? (v & ~lev_q[idx]) : (v & lev_q[idx]);
          for (int i = 0; i < 32; i++) begin
            p = 32 * idx + i;
            if (p < PinCountDefault && chg[i] && fsel_q[p] == FselOutput)
              drv_q[p] = (op == OpSet);
          end
          // the second bank takes all 32 bits, pins beyond the count included
          if (op == OpSet) begin
            lev_q[idx] |= v;
            eds_q[idx] |= (en_q[SlotRise][idx] | en_q[SlotARise][idx]) & chg;
          end else begin
            lev_q[idx] &= ~v;
            eds_q[idx] |= (en_q[SlotFall][idx] | en_q[SlotAFall][idx]) & chg;
          end
          latch_levels(idx);
        end
      end
      OpLevel: if (acc.mode == ModeRd) rd = lev_q[idx];
      OpStatus: begin
        if (acc.mode == ModeWr) eds_q[idx] &= ~v;
        else rd = eds_q[idx];
      end
      OpRise, OpFall, OpHigh, OpLow, OpARise, OpAFall: begin
        if (acc.mode == ModeWr) begin
          en_q[slot][idx] = v;
          latch_levels(0);
          latch_levels(1);
        end else begin
          rd = en_q[slot][idx];
        end
      end
      default: ;
    endcase
    res.read_data   = (acc.mode == ModeWr) ? '0 : rd;
    res.irq_lines   = {|(eds_q[1] & Irq2Mask1),
                       |(eds_q[0] & Irq1Mask0) || |(eds_q[1] & Irq1Mask1),
                       |(eds_q[0] & Irq0Mask0)};
    res.pin_outputs = drv_q[PinOutWidth-1:0];
    res.sd_route    = sd_q;
    res.bad_offset  = (op == OpBad);
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom & $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed register traffic, with unaligned and unmapped noise.
  function automatic gpio_in_t rand_access();
    gpio_in_t    acc;
    int unsigned r;
    int unsigned idx;
    r = $urandom_range(99);
    idx = $urandom_range(1);
    acc.mode = ($urandom_range(9) < 6) ? ModeWr : ModeRd;
    acc.write_data = rand_word();
    if (r < 12) begin
      idx = $urandom_range(FselWords - 1);
      acc.address = AddrFsel0 + 12'(4 * idx);
      case ($urandom_range(3))
        0: acc.write_data = FselAllOut;
        1: acc.write_data = (idx >= 4) ? FselAllAlt0 : 32'h0;
        default: ;
      endcase
    end else if (r < 36) begin
      acc.mode = ($urandom_range(9) == 0) ? ModeRd : ModeWr;
      if ($urandom_range(1)) acc.address = idx ? AddrSet1 : AddrSet0;
      else acc.address = idx ? AddrClr1 : AddrClr0;
    end else if (r < 44) begin
      acc.address = idx ? AddrLev1 : AddrLev0;
    end else if (r < 56) begin
      acc.address = idx ? AddrEds1 : AddrEds0;
    end else if (r < 80) begin
      acc.address = AddrRen0 + 12'(EnStride * $urandom_range(5)) + 12'(4 * idx);
    end else if (r < 86) begin
      acc.address = AddrPud + 12'(4 * $urandom_range(2));
    end else if (r < 93) begin
      acc.address = 12'($urandom_range(4095));
    end else begin
      acc.address = 12'($urandom_range(AddrPudClk1 + 3));
    end
    return acc;
  endfunction

  task automatic drive_access(input gpio_in_t acc, input logic known,
                              input logic [31:0] rd, input logic bad);
    gpio_out_t   res;
    gpio_op_e    op;
    int unsigned idx;
    // idle with the sender's idle share, drawn again at each clock edge
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= acc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_access(acc);
    if (known) begin
      res.read_data  = rd;
      res.bad_offset = bad;
    end
    pending_results.push_back(res);
    op = decode_addr(acc.address, idx);
    kind_seen[op] = 1'b1;
    if (acc.mode == ModeWr) n_wr++;
    else n_rd++;
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    @(hold_ev);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    gpio_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, out_data);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("read_data", 64'(want.read_data), 64'(out_data.read_data));
        check_field("irq_lines", 64'(want.irq_lines), 64'(out_data.irq_lines));
        check_field("pin_outputs", 64'(want.pin_outputs), 64'(out_data.pin_outputs));
        check_field("sd_route", 64'(want.sd_route), 64'(out_data.sd_route));
        check_field("bad_offset", 64'(want.bad_offset), 64'(out_data.bad_offset));
        if (out_data.irq_lines != '0) n_irq++;
        if (out_data.sd_route) n_sd2++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirTable[k])
      drive_access(DirTable[k].acc, DirTable[k].known, DirTable[k].rd, DirTable[k].bad);

    tx_idle_pct = 32;
    rx_idle_pct = 73;
    repeat (PhaseItems) drive_access(rand_access(), 1'b0, '0, 1'b0);

    tx_idle_pct = 73;
    rx_idle_pct = 32;
    repeat (PhaseItems) drive_access(rand_access(), 1'b0, '0, 1'b0);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    -> hold_ev;
    repeat (PhaseItems) drive_access(rand_access(), 1'b0, '0, 1'b0);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d transactions (%0d reads, %0d writes) over %0d register kinds.",
             n_checked, n_rd, n_wr, kind_seen.num());
    $display("Results with an interrupt pending: %0d, with the second SD route: %0d.",
             n_irq, n_sd2);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/gpioevt_pkg.sv
src/gpio_register_block_with_event_detect_core.sv
tb/sv/tb_gpio_register_block_with_event_detect_core.sv
